FILE: rtl/dbc_pkg.sv
// dbc_pkg: shared constants for the density blob clustering core
// no dependencies; imported by the core and its divider
package dbc_pkg;

	// configuration register indexes
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_MIN_NB = 1'b1;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;
	localparam int MIN_NB_BITS    = 7;

	localparam logic [15:0] RADIUS_RESET = 16'd256;
	localparam logic [6:0]  MIN_NB_RESET = 7'd4;

	// result limits and widths
	localparam int RESULT_LIMIT = 64;
	localparam int RES_BITS     = 7;
	localparam int COUNT_BITS   = 13;

endpackage

FILE: rtl/dbc_div.sv
// dbc_div: restoring divider, signed dividend by unsigned divisor, one bit a cycle
// quotient truncated toward zero; depends on dbc_pkg
module dbc_div #(
	parameter int SW = 29,
	parameter int CW = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [SW-1:0] dividend,
	input  logic        [CW-1:0] divisor,
	output logic                 done,
	output logic signed [SW-1:0] quotient
);
	import dbc_pkg::*;

	localparam int KW = $clog2(SW + 1);

	logic [CW:0]   rem_q;
	logic [SW-1:0] quo_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [CW:0]   trial;
	logic          ge;

	// one trial subtraction per cycle
	assign trial = {rem_q[CW-1:0], quo_q[SW-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q  <= dividend[SW-1];
				quo_q  <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
				rem_q  <= '0;
				cnt_q  <= KW'(SW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? (trial - {1'b0, divisor}) : trial;
				quo_q <= {quo_q[SW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/density_blob_clustering_core.sv
// density_blob_clustering_core: DBSCAN-style clustering of a loaded 2-D point set
// depends on dbc_pkg and dbc_div
//
// Usage: points enter on the s_ stream, one transaction each, x in s_tdata low
// bits, y above it; s_tlast marks the final point and starts clustering. A point
// that arrives with the store full is dropped. Clustering reuses one distance
// pipeline (memory read, abs/compare, square, sum/compare) that scans all n
// stored points. Each visited point costs one scan for its neighbour count, and
// each core point one more to expand it; a set also takes sweeps of the pending
// marks and two serial divisions per cluster. s_tready is low for the whole run.
// Results leave on the m_ stream, one per cluster (at most 64), m_tuser set; the
// final one has m_tlast. With no cluster a single item with m_tuser low and
// m_tlast high is sent. A stalled receiver holds the output register and, once a
// third result is ready, the sequencer waits. Reset clears the point count and
// all marks and loads radius 256 and min_neighbours 4; the point store is not
// cleared. The user must write the cfg port only while the core is idle; the
// core itself does not enforce this.
module density_blob_clustering_core #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [dbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dbc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// point input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata: point_x, point_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	input  logic                                 s_tlast,
	// result output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata: center_x, center_y, min_x, max_x, min_y, max_y, contribution_count
	output logic [((6*COORD_BITS+dbc_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
	// m_tuser: blob_valid
	output logic                                 m_tuser,
	output logic                                 m_tlast
);
	import dbc_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW  = $clog2(MAX_POINTS + 1);
	localparam int CW  = $clog2(MAX_POINTS * MAX_POINTS + 2);
	localparam int SW  = C + CW;
	localparam int DW  = (C + 1 > 16) ? C + 1 : 16;
	localparam int MW  = (NW > MIN_NB_BITS) ? NW : MIN_NB_BITS;
	localparam int BW  = 6 * C + COUNT_BITS;
	localparam int OW  = ((BW + 7) / 8) * 8;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_OUTER = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_SWEEP = 8'b0000_1000,
		S_DIVX  = 8'b0001_0000,
		S_DIVY  = 8'b0010_0000,
		S_DONE  = 8'b0100_0000,
		S_FINAL = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0]            radius_q;
	logic [MIN_NB_BITS-1:0] min_nb_q;
	logic [31:0]            r2_q;

	// point store
	logic signed [C-1:0] x_mem [MAX_POINTS];
	logic signed [C-1:0] y_mem [MAX_POINTS];
	logic [NW-1:0]       n_q;

	// sequencer bookkeeping
	logic [MAX_POINTS-1:0] visited_q;
	logic [MAX_POINTS-1:0] pending_q;
	logic [NW-1:0]         i_q;
	logic [NW-1:0]         k_q;
	logic [IW-1:0]         cur_q;
	logic                  found_q;
	logic                  ctx_outer_q;
	logic                  mode_cnt_q;
	logic [NW-1:0]         cnt_q;
	logic [RES_BITS-1:0]   nres_q;

	// scan issue
	logic          scan_q;
	logic [NW-1:0] j_q;
	logic          issue;
	logic          scan_done;

	// distance pipeline
	logic signed [C-1:0] px_q, py_q;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [IW-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [C-1:0] xj_s1, yj_s1, xj_s2, yj_s2, xj_s3, yj_s3, xj_s4, yj_s4;
	logic [15:0]         ax_s2, ay_s2;
	logic                far_s2, far_s3;
	logic [31:0]         sqx_s3, sqy_s3;
	logic                near_s4;
	logic signed [C:0]   dx, dy;
	logic [C:0]          adx, ady;
	logic [DW-1:0]       adxw, adyw;

	// cluster accumulators
	logic [CW-1:0]        contrib_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q;
	logic signed [C-1:0]  bx0_q, bx1_q, by0_q, by1_q;
	logic signed [C-1:0]  qx_q;
	logic signed [C-1:0]  qy_q;

	// result holding and output
	logic          held_q;
	logic [BW-1:0] held_data_q;
	logic          out_valid_q;
	logic [BW-1:0] out_data_q;
	logic          out_flag_q;
	logic          out_last_q;
	logic          out_free;

	// divider
	logic                 div_start_q;
	logic                 div_done;
	logic signed [SW-1:0] div_quo;
	logic signed [SW-1:0] div_num;
	logic                 core;

	assign s_tready  = (state_q == S_IDLE);
	assign issue     = scan_q && (j_q < n_q);
	assign scan_done = scan_q && (j_q == n_q) && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign core      = MW'(cnt_q) >= MW'(min_nb_q);
	assign out_free  = !out_valid_q || m_tready;
	assign div_num   = (state_q == S_DIVY) ? sum_y_q : sum_x_q;

	// point store, two read ports: scanned point and center point
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && (n_q < NW'(MAX_POINTS))) begin
			x_mem[n_q[IW-1:0]] <= s_tdata[C-1:0];
			y_mem[n_q[IW-1:0]] <= s_tdata[2*C-1:C];
		end
		xj_s1 <= x_mem[j_q[IW-1:0]];
		yj_s1 <= y_mem[j_q[IW-1:0]];
		px_q  <= x_mem[cur_q];
		py_q  <= y_mem[cur_q];
	end

	// distance pipeline datapath
	assign dx   = {xj_s1[C-1], xj_s1} - {px_q[C-1], px_q};
	assign dy   = {yj_s1[C-1], yj_s1} - {py_q[C-1], py_q};
	assign adx  = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
	assign ady  = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
	assign adxw = DW'(adx);
	assign adyw = DW'(ady);

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		xj_s2  <= xj_s1;
		yj_s2  <= yj_s1;
		ax_s2  <= adxw[15:0];
		ay_s2  <= adyw[15:0];
		far_s2 <= (adxw > DW'(radius_q)) || (adyw > DW'(radius_q));
		idx_s3 <= idx_s2;
		xj_s3  <= xj_s2;
		yj_s3  <= yj_s2;
		far_s3 <= far_s2;
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		idx_s4 <= idx_s3;
		xj_s4  <= xj_s3;
		yj_s4  <= yj_s3;
		near_s4 <= !far_s3 && (({1'b0, sqx_s3} + {1'b0, sqy_s3}) <= {1'b0, r2_q});
		r2_q   <= radius_q * radius_q;
	end

	dbc_div #(
		.SW(SW),
		.CW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num),
		.divisor  (contrib_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer, pipeline valids and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			radius_q    <= RADIUS_RESET;
			min_nb_q    <= MIN_NB_RESET;
			n_q         <= '0;
			visited_q   <= '0;
			pending_q   <= '0;
			i_q         <= '0;
			k_q         <= '0;
			cur_q       <= '0;
			found_q     <= 1'b0;
			ctx_outer_q <= 1'b0;
			mode_cnt_q  <= 1'b0;
			cnt_q       <= '0;
			nres_q      <= '0;
			scan_q      <= 1'b0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			idx_s1      <= '0;
			contrib_q   <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			bx0_q       <= '0;
			bx1_q       <= '0;
			by0_q       <= '0;
			by1_q       <= '0;
			qx_q        <= '0;
			qy_q        <= '0;
			held_q      <= 1'b0;
			held_data_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_flag_q  <= 1'b0;
			out_last_q  <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;

			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data[15:0];
					REG_MIN_NB: min_nb_q <= cfg_data[MIN_NB_BITS-1:0];
					default: ;
				endcase
			end

			// output register drains on a completed transaction
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;

			// scan issue and pipeline valids
			v_s1   <= issue;
			idx_s1 <= j_q[IW-1:0];
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			if (issue)
				j_q <= j_q + 1'b1;

			// consume one neighbour test result
			if (v_s4 && near_s4) begin
				if (mode_cnt_q) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					contrib_q <= contrib_q + 1'b1;
					sum_x_q   <= sum_x_q + SW'(xj_s4);
					sum_y_q   <= sum_y_q + SW'(yj_s4);
					if (xj_s4 < bx0_q) bx0_q <= xj_s4;
					if (xj_s4 > bx1_q) bx1_q <= xj_s4;
					if (yj_s4 < by0_q) by0_q <= yj_s4;
					if (yj_s4 > by1_q) by1_q <= yj_s4;
					if (!visited_q[idx_s4])
						pending_q[idx_s4] <= 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (n_q < NW'(MAX_POINTS))
							n_q <= n_q + 1'b1;
						if (s_tlast) begin
							i_q     <= '0;
							nres_q  <= '0;
							held_q  <= 1'b0;
							state_q <= S_OUTER;
						end
					end
				end

				// next seed candidate in index order
				S_OUTER: begin
					if (i_q == n_q) begin
						state_q <= S_FINAL;
					end else begin
						i_q <= i_q + 1'b1;
						if (!visited_q[i_q[IW-1:0]]) begin
							visited_q[i_q[IW-1:0]] <= 1'b1;
							cur_q       <= i_q[IW-1:0];
							ctx_outer_q <= 1'b1;
							mode_cnt_q  <= 1'b1;
							cnt_q       <= '0;
							j_q         <= '0;
							scan_q      <= 1'b1;
							state_q     <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					if (scan_done) begin
						if (mode_cnt_q) begin
							if (core) begin
								if (ctx_outer_q) begin
									contrib_q <= CW'(1);
									sum_x_q   <= SW'(px_q);
									sum_y_q   <= SW'(py_q);
									bx0_q     <= px_q;
									bx1_q     <= px_q;
									by0_q     <= py_q;
									by1_q     <= py_q;
								end
								mode_cnt_q <= 1'b0;
								j_q        <= '0;
							end else begin
								scan_q  <= 1'b0;
								state_q <= ctx_outer_q ? S_OUTER : S_SWEEP;
							end
						end else begin
							scan_q  <= 1'b0;
							state_q <= S_SWEEP;
							if (ctx_outer_q) begin
								k_q     <= '0;
								found_q <= 1'b0;
							end
						end
					end
				end

				// sweep the pending marks until a pass finds none
				S_SWEEP: begin
					if (k_q == n_q) begin
						if (found_q) begin
							k_q     <= '0;
							found_q <= 1'b0;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIVX;
						end
					end else begin
						k_q <= k_q + 1'b1;
						if (pending_q[k_q[IW-1:0]]) begin
							pending_q[k_q[IW-1:0]] <= 1'b0;
							found_q <= 1'b1;
							if (!visited_q[k_q[IW-1:0]]) begin
								visited_q[k_q[IW-1:0]] <= 1'b1;
								cur_q       <= k_q[IW-1:0];
								ctx_outer_q <= 1'b0;
								mode_cnt_q  <= 1'b1;
								cnt_q       <= '0;
								j_q         <= '0;
								scan_q      <= 1'b1;
								state_q     <= S_SCAN;
							end
						end
					end
				end

				S_DIVX: begin
					if (div_done) begin
						qx_q        <= div_quo[C-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_DIVY;
					end
				end

				S_DIVY: begin
					if (div_done) begin
						qy_q    <= div_quo[C-1:0];
						state_q <= S_DONE;
					end
				end

				// pass the previous cluster on, keep the new one back; at the result limit drop it
				S_DONE: begin
					if (nres_q == RES_BITS'(RESULT_LIMIT)) begin
						state_q <= S_OUTER;
					end else if (!held_q || out_free) begin
						if (held_q) begin
							out_valid_q <= 1'b1;
							out_data_q  <= held_data_q;
							out_flag_q  <= 1'b1;
							out_last_q  <= 1'b0;
						end
						held_data_q <= {COUNT_BITS'(contrib_q), by1_q, by0_q, bx1_q, bx0_q,
							qy_q, qx_q};
						held_q  <= 1'b1;
						nres_q  <= nres_q + 1'b1;
						state_q <= S_OUTER;
					end
				end

				// last result of the set, then clear for the next set
				S_FINAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= held_q ? held_data_q : '0;
						out_flag_q  <= held_q;
						out_last_q  <= 1'b1;
						held_q      <= 1'b0;
						n_q         <= '0;
						visited_q   <= '0;
						pending_q   <= '0;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// held_data_q keeps the newest cluster until S_DONE or S_FINAL moves it out
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OW'(out_data_q);
	assign m_tuser  = out_flag_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: tb/cluster_checker.sv
// cluster_checker: watches the point and result streams of the clustering core,
// predicts each set's blobs and compares them; depends on dbc_pkg
module cluster_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         m_tuser,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending_blobs
);
	import dbc_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [15:0] cx, cy, x0, x1, y0, y1;
		logic [12:0] count;
		logic        last;
	} blob_t;

	blob_t blob_q[$];
	logic [15:0] radius_r;
	logic [6:0]  min_nb_r;
	longint      px[64], py[64];
	int          npts;

	// open cluster state
	bit          seen[64], pend[64];
	longint      sx, sy, bx0, bx1, by0, by1, c;

	function automatic bit near(int a, int b);
		longint dx, dy;
		dx = px[a] - px[b];
		dy = py[a] - py[b];
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx > radius_r || dy > radius_r) return 0;
		return dx * dx + dy * dy <= longint'(radius_r) * longint'(radius_r);
	endfunction

	function automatic int nb_count(int p);
		int c;
		c = 0;
		for (int j = 0; j < npts; j++) if (near(p, j)) c++;
		return c;
	endfunction

	// add every neighbour of one core point to the open cluster
	task automatic expand_pt(int p);
		for (int j = 0; j < npts; j++) begin
			if (near(p, j)) begin
				c++; sx += px[j]; sy += py[j];
				if (px[j] < bx0) bx0 = px[j];
				if (px[j] > bx1) bx1 = px[j];
				if (py[j] < by0) by0 = py[j];
				if (py[j] > by1) by1 = py[j];
				if (!seen[j]) pend[j] = 1;
			end
		end
	endtask

	// cluster the stored set and queue one blob per cluster up to the result limit,
	task automatic cluster_set();
		bit     found;
		int     nres;
		blob_t  b;
		nres = 0;
		foreach (seen[i]) begin
			seen[i] = 0;
			pend[i] = 0;
		end
		for (int i = 0; i < npts; i++) begin
			if (seen[i]) continue;
			seen[i] = 1;
			if (nb_count(i) < min_nb_r) continue;
			c = 1; sx = px[i]; sy = py[i];
			bx0 = px[i]; bx1 = px[i]; by0 = py[i]; by1 = py[i];
			expand_pt(i);
			// sweep the pending marks until a pass finds none
			do begin
				found = 0;
				for (int k = 0; k < npts; k++) begin
					if (!pend[k]) continue;
					pend[k] = 0;
					found = 1;
					if (seen[k]) continue;
					seen[k] = 1;
					if (nb_count(k) >= min_nb_r) expand_pt(k);
				end
			end while (found);
			if (nres < RESULT_LIMIT) begin
				b.valid = 1;
				b.cx = 16'(sx / c);
				b.cy = 16'(sy / c);
				b.x0 = 16'(bx0); b.x1 = 16'(bx1);
				b.y0 = 16'(by0); b.y1 = 16'(by1);
				b.count = 13'(c);
				b.last = 0;
				blob_q = {blob_q, b};
				nres++;
			end
		end
		if (nres == 0) begin
			b = '0;
			b.last = 1;
			blob_q = {blob_q, b};
		end else begin
			blob_q[blob_q.size() - 1].last = 1;
		end
		npts = 0;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	// configuration, point and result transactions
	always @(posedge clk or negedge arst_n) begin
		blob_t w;
		if (!arst_n) begin
			radius_r = RADIUS_RESET;
			min_nb_r = MIN_NB_RESET;
			npts = 0;
			fail_count = 0;
			blob_q.delete();
			pending_blobs = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_RADIUS) radius_r = cfg_data;
				else min_nb_r = cfg_data[6:0];
			end
			if (s_tvalid && s_tready) begin
				if (npts < 64) begin
					px[npts] = longint'($signed(s_tdata[15:0]));
					py[npts] = longint'($signed(s_tdata[31:16]));
					npts++;
				end
				if (s_tlast) cluster_set();
			end
			if (m_tvalid && m_tready) begin
				if (blob_q.size() == 0) begin
					report("unexpected result", m_tdata[31:0], 0);
				end else begin
					w = blob_q.pop_front();
					if (m_tuser !== w.valid) report("blob_valid", m_tuser, w.valid);
					if (m_tdata[15:0] !== w.cx) report("center_x", m_tdata[15:0], w.cx);
					if (m_tdata[31:16] !== w.cy) report("center_y", m_tdata[31:16], w.cy);
					if (m_tdata[47:32] !== w.x0) report("min_x", m_tdata[47:32], w.x0);
					if (m_tdata[63:48] !== w.x1) report("max_x", m_tdata[63:48], w.x1);
					if (m_tdata[79:64] !== w.y0) report("min_y", m_tdata[79:64], w.y0);
					if (m_tdata[95:80] !== w.y1) report("max_y", m_tdata[95:80], w.y1);
					if (m_tdata[108:96] !== w.count)
						report("contribution_count", m_tdata[108:96], w.count);
					if (m_tlast !== w.last) report("last_blob", m_tlast, w.last);
				end
			end
			pending_blobs = blob_q.size();
		end
	end
endmodule

FILE: tb/testbench.sv
// testbench: point-set stimulus, configuration phases and verdict for the
// clustering core; depends on dbc_pkg, the core and cluster_checker
module testbench;
	import dbc_pkg::*;

	logic         clk = 0, arst_n = 0;
	logic         cfg_we = 0, cfg_index = 0;
	logic [15:0]  cfg_data = 0;
	logic         s_tvalid = 0, s_tready, s_tlast = 0;
	logic [31:0]  s_tdata = 0;
	logic         m_tvalid, m_tready = 0, m_tuser, m_tlast;
	logic [111:0] m_tdata;
	int           fail_count, pending_blobs;
	bit           stim_done = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	density_blob_clustering_core DUT (.*);
	cluster_checker checker_i (.*);

	// receiver stalls
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 3) == 0) gap = 0;
			m_tready = 0;
			repeat (gap) @(negedge clk);
			m_tready = 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_point(logic [15:0] x, logic [15:0] y, logic last, bit burst);
		if (!burst) repeat ($urandom_range(0, 15)) @(negedge clk);
		s_tdata = {y, x};
		s_tlast = last;
		s_tvalid = 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic wait_idle();
		while (pending_blobs != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// clustered random set around a few centers
	task automatic random_set(int n, int spread);
		logic [15:0] cx, cy;
		bit burst;
		burst = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < n; i++) begin
			if (i % 4 == 0) begin
				cx = 16'($urandom); cy = 16'($urandom);
			end
			send_point(cx + 16'($urandom_range(0, spread)), cy - 16'($urandom_range(0, spread)),
				i == n - 1, burst);
		end
	endtask

	initial begin
		int sent;
		int n;
		repeat (4) @(negedge clk);
		arst_n = 1;
		// directed: reset settings, lone point, no cluster, extremes
		send_point(16'h0000, 16'h0000, 1'b1, 1'b0);
		send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
		send_point(16'h7fff, 16'h7fff, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_MIN_NB, 16'd1);
		write_reg(REG_RADIUS, 16'd0);
		send_point(16'h8000, 16'h7fff, 1'b0, 1'b0);
		send_point(16'h8000, 16'h7fff, 1'b0, 1'b0);
		send_point(16'h7fff, 16'h8000, 1'b0, 1'b0);
		send_point(16'hffff, 16'h0001, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_RADIUS, 16'hffff);
		send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
		send_point(16'h7fff, 16'h7fff, 1'b0, 1'b0);
		send_point(16'h1234, 16'hedcb, 1'b1, 1'b0);
		wait_idle();
		// store overflow, the final two points dropped
		write_reg(REG_RADIUS, 16'd0);
		for (int i = 0; i < 66; i++) send_point(16'(i * 97), 16'(-i * 31), i == 65, 1'b1);
		wait_idle();
		// random phases
		sent = 0;
		while (sent < 55) begin
			write_reg(REG_RADIUS, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600)));
			write_reg(REG_MIN_NB, 16'($urandom_range(1, 6)));
			n = $urandom_range(1, 14);
			random_set(n, $urandom_range(0, 1) ? 400 : 65535);
			sent += n;
			wait_idle();
		end
		write_reg(REG_MIN_NB, 16'd64);
		write_reg(REG_RADIUS, 16'd256);
		random_set(5, 100);
		wait_idle();
		repeat (200) @(negedge clk);
		stim_done = 1;
	end

	// verdict
	initial begin
		wait (stim_done);
		if (fail_count == 0 && pending_blobs == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	// timeout
	initial begin
		#100000000;
		$display("simulation failed");
		$finish;
	end
endmodule
